// ===== src/bounded_value_set_top_macros.svh =====
// ---------------------------------------------------------------------------
// bounded value set assertion macros
// shared concurrent assertion forms for the bounded value set rtl
// ---------------------------------------------------------------------------
`ifndef BOUNDED_VALUE_SET_TOP_MACROS_SVH
`define BOUNDED_VALUE_SET_TOP_MACROS_SVH

// checked outside reset
`define BVS_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BVS_ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/bvs_pkg.sv =====
// ---------------------------------------------------------------------------
// bvs_pkg
// action codes, field widths and control types of the bounded value set
// ---------------------------------------------------------------------------
`default_nettype none

package bvs_pkg;

   localparam int ACTION_W      = 2;
   localparam int REQ_VALUE_W   = 32;
   localparam int INDEX_W       = 4;
   localparam int ITEM_W        = 32;
   localparam int COUNT_W       = 5;
   localparam int CAP_W         = 5;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 40;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [ACTION_W-1:0] ACT_INSERT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ERASE    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CONTAINS = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_GET      = 2'd3;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                exec;
      logic [ACTION_W-1:0] action;
      logic                do_insert;
   } bvs_ctl_type;

endpackage

`default_nettype wire

// ===== src/bvs_cell.sv =====
// ---------------------------------------------------------------------------
// bvs_cell
// one slot of the set: compare, neighbor shift on erase, append, read tap
// ---------------------------------------------------------------------------
`default_nettype none

module bvs_cell
   import bvs_pkg::*;
#(
   parameter int POS        = 0,
   parameter int VALUE_BITS = 32,
   parameter int HELD_W     = 5
) (
   input  wire logic                  clock,
   input  wire bvs_ctl_type           ctl,
   input  wire logic [VALUE_BITS-1:0] key,
   input  wire logic [HELD_W-1:0]     held,
   input  wire logic [INDEX_W-1:0]    index,
   input  wire logic [VALUE_BITS-1:0] next_value,
   input  wire logic                  seen_in,
   input  wire logic [VALUE_BITS-1:0] rd_in,
   output logic      [VALUE_BITS-1:0] value,
   output logic                       seen_out,
   output logic      [VALUE_BITS-1:0] rd_out
);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  live;
   logic                  hit;
   logic                  shift;
   logic                  append;

   assign live     = 32'(held) > 32'(POS);
   assign hit      = live && (value_ff == key);
   assign seen_out = seen_in | hit;

   // slots at and above the erased one take their upper neighbor
   assign shift  = ctl.exec && (ctl.action == ACT_ERASE) && seen_out;
   assign append = ctl.exec && (ctl.action == ACT_INSERT) && ctl.do_insert &&
                   (32'(held) == 32'(POS));

   always_comb begin
      value_in = value_ff;
      if (shift) begin
         value_in = next_value;
      end else if (append) begin
         value_in = key;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value  = value_ff;
   assign rd_out = (live && (32'(index) == 32'(POS))) ? (rd_in | value_ff) : rd_in;

endmodule

`default_nettype wire

// ===== src/bounded_value_set_top.sv =====
// ---------------------------------------------------------------------------
// bounded_value_set_top
// insertion-ordered set of distinct values built from a row of slot cells
// ---------------------------------------------------------------------------
// The set holds up to min(capacity, DEPTH) distinct values in the order they
// were inserted. Each request transaction carries one action: insert appends
// a value that is absent while there is room, erase removes a present value
// and slides every later entry down one slot, contains reports presence, get
// reads the entry at an index below the count. Every response transaction
// carries ok and the count after the action; item is the entry read by a
// successful get and zero otherwise. The row of DEPTH cells compares the key
// against all slots combinationally. A taken request waits in the holding stage,
// executes once the response register is free or draining, and its response is
// registered in the response register; one transaction per cycle is sustained
// while the response side keeps taking. A response waiting in the output register
// still lets one more request into the holding stage; the request side stalls
// only once both are occupied. The capacity register resets to
// 16, is written through the csr channel and should only be written while no
// transaction is in flight; lowering it below the count drops nothing, it only
// refuses inserts until the count falls below it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bounded_value_set_top_macros.svh"

module bounded_value_set_top
   import bvs_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // value[31:0], index[35:32], zero pad
   input  wire logic [ACTION_W-1:0]    req_tuser,  // action[1:0]

   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,  // item[31:0], count[36:32], zero pad
   output logic      [0:0]             rsp_tuser,  // ok[0]

   // capacity register write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CAP_W-1:0]       csr_data
);

   localparam int HELD_W = $clog2(DEPTH + 1);

   // capacity register, always writable
   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;

   // request holding stage
   logic                  req_valid_ff;
   logic                  req_valid_in;
   logic [ACTION_W-1:0]   act_ff;
   logic [ACTION_W-1:0]   act_in;
   logic [VALUE_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0] key_in;
   logic [INDEX_W-1:0]    idx_ff;
   logic [INDEX_W-1:0]    idx_in;

   // number of values held
   logic [HELD_W-1:0] held_ff;
   logic [HELD_W-1:0] held_in;

   // response register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_ok_ff;
   logic              rsp_ok_in;
   logic [ITEM_W-1:0] rsp_item_ff;
   logic [ITEM_W-1:0] rsp_item_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;

   logic        req_take;
   logic        exec;
   logic        found;
   logic        full;
   logic        get_ok;
   logic        ok;
   bvs_ctl_type ctl;

   // cell row wiring: slot values, match chain and read chain
   logic [VALUE_BITS-1:0] slot_value [DEPTH];
   logic                  seen       [DEPTH+1];
   logic [VALUE_BITS-1:0] rd         [DEPTH+1];

   // ---------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------
   // the held request runs once the response register is free or draining
   assign exec       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || exec;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------
   // capacity register
   // ---------------------------------------------------------------
   always_comb begin
      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
   end

   // ---------------------------------------------------------------
   // request stage, value masked to the stored width on the way in
   // ---------------------------------------------------------------
   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !exec);
      act_in       = act_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      if (req_take) begin
         act_in = req_tuser;
         key_in = VALUE_BITS'(req_tdata[REQ_VALUE_W-1:0]);
         idx_in = req_tdata[REQ_VALUE_W +: INDEX_W];
      end
   end

   // ---------------------------------------------------------------
   // cell row
   // ---------------------------------------------------------------
   assign seen[0] = 1'b0;
   assign rd[0]   = '0;

   assign ctl.exec      = exec;
   assign ctl.action    = act_ff;
   assign ctl.do_insert = !found && !full;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_BITS-1:0] upper;

      // top slot has no upper neighbor; what it loads there is past the count
      if (i == DEPTH - 1) begin : g_top
         assign upper = slot_value[i];
      end else begin : g_mid
         assign upper = slot_value[i+1];
      end

      bvs_cell #(
         .POS        (i),
         .VALUE_BITS (VALUE_BITS),
         .HELD_W     (HELD_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (key_ff),
         .held       (held_ff),
         .index      (idx_ff),
         .next_value (upper),
         .seen_in    (seen[i]),
         .rd_in      (rd[i]),
         .value      (slot_value[i]),
         .seen_out   (seen[i+1]),
         .rd_out     (rd[i+1])
      );
   end

   // ---------------------------------------------------------------
   // action decode
   // ---------------------------------------------------------------
   assign found  = seen[DEPTH];
   // limit saturates at the depth; capacity zero refuses every insert
   assign full   = (32'(held_ff) >= DEPTH) || (32'(held_ff) >= 32'(cap_ff));
   assign get_ok = 32'(idx_ff) < 32'(held_ff);

   always_comb begin
      unique case (act_ff)
         ACT_INSERT:   ok = !found && !full;
         ACT_ERASE:    ok = found;
         ACT_CONTAINS: ok = found;
         ACT_GET:      ok = get_ok;
         default:      ok = 1'b0;
      endcase
   end

   always_comb begin
      held_in = held_ff;
      if (exec && (act_ff == ACT_INSERT) && ok) begin
         held_in = held_ff + 1'b1;
      end else if (exec && (act_ff == ACT_ERASE) && ok) begin
         held_in = held_ff - 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);
      rsp_ok_in    = rsp_ok_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_count_in = rsp_count_ff;
      if (exec) begin
         rsp_ok_in    = ok;
         rsp_item_in  = ((act_ff == ACT_GET) && get_ok) ? ITEM_W'(rd[DEPTH]) : '0;
         rsp_count_in = COUNT_W'(held_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         req_valid_ff <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         req_valid_ff <= req_valid_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_item_ff  <= rsp_item_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - ITEM_W - COUNT_W){1'b0}}, rsp_count_ff, rsp_item_ff};
   assign rsp_tuser  = rsp_ok_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   `BVS_ASSERT_ALL(a_reset_clears, reset |=> (held_ff == '0) && !rsp_valid_ff, "reset did not clear the set")
   `BVS_ASSERT_CLK(a_held_idle, !exec |=> $stable(held_ff), "count moved without an executed transaction")
   `BVS_ASSERT_CLK(a_insert_grows, (exec && (act_ff == ACT_INSERT) && ok) |=> (held_ff == $past(held_ff) + 1'b1), "accepted insert did not grow the count")
   `BVS_ASSERT_CLK(a_held_bound, (32'(held_ff) <= DEPTH) && (rsp_valid_ff || !exec || rsp_valid_in), "count beyond depth or executed transaction lost")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the insertion-ordered bounded value set
// ---------------------------------------------------------------------------
// A short table of hand-picked requests runs first: empty set reads, the
// extreme values, duplicate insert, erase at the head, middle and tail, get
// beyond the count, capacity zero, capacity lowered below the count and
// capacity above the depth. Rows whose answer is obvious carry it typed in;
// the rest are scored by the bench's own model of the set. Random phases
// follow. They draw values mostly from a small pool so that hits, duplicates
// and a full set happen often. Each phase writes its capacity from a list
// and takes one of four idle patterns on the request and response sides.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
   import bvs_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_DEPTH      = 16;
   localparam int POOL_SIZE      = 24;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 56;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DIR_ROWS       = 29;

   // one response transaction as the bench predicts it
   typedef struct packed {
      logic              ok;
      logic [ITEM_W-1:0] item;
      logic [COUNT_W-1:0] count;
   } set_rsp_type;

   // one row of the directed table: either a capacity write or a request
   typedef struct packed {
      logic                  is_cfg;
      logic [CAP_W-1:0]      cap;
      logic [ACTION_W-1:0]   act;
      logic [REQ_VALUE_W-1:0] val;
      logic [INDEX_W-1:0]    idx;
      logic                  typed;
      logic                  ok;
      logic [ITEM_W-1:0]     item;
      logic [COUNT_W-1:0]    count;
   } dir_row_type;

   // clock, reset and every dut input start at a known value
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [ACTION_W-1:0]    req_tuser  = ACT_INSERT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CAP_W-1:0]       csr_data   = '0;

   // bench copy of the set contents and the capacity register
   logic [REQ_VALUE_W-1:0] set_vals [SET_DEPTH];
   int unsigned            set_count    = 0;
   logic [CAP_W-1:0]       set_capacity = CAP_RESET;

   // responses still owed by the dut, oldest first
   set_rsp_type            rsp_due [$];

   // idle pattern of the current phase, in percent
   int unsigned            send_idle_pct = 0;
   int unsigned            stall_pct     = 0;

   int unsigned            error_count   = 0;
   int unsigned            req_total     = 0;
   int unsigned            cap_writes    = 0;
   int unsigned            inserts_taken = 0;
   int unsigned            gets_hit      = 0;

   // directed stimulus; typed answers only where they are plain to see
   dir_row_type dir_rows [DIR_ROWS] = '{
      // empty set after reset
      '{1'b0, 5'd0,  ACT_GET,      32'h0000_0000, 4'd0,  1'b1, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_CONTAINS, 32'h0000_0000, 4'd0,  1'b1, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_ERASE,    32'h0000_0005, 4'd0,  1'b1, 1'b0, 32'h0,         5'd0},
      // extreme values, then a duplicate
      '{1'b0, 5'd0,  ACT_INSERT,   32'h0000_0000, 4'd0,  1'b1, 1'b1, 32'h0,         5'd1},
      '{1'b0, 5'd0,  ACT_INSERT,   32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1, 32'h0,         5'd2},
      '{1'b0, 5'd0,  ACT_INSERT,   32'h0000_0000, 4'd0,  1'b1, 1'b0, 32'h0,         5'd2},
      '{1'b0, 5'd0,  ACT_GET,      32'hFFFF_FFFF, 4'd0,  1'b1, 1'b1, 32'h0,         5'd2},
      '{1'b0, 5'd0,  ACT_GET,      32'h0000_0000, 4'd1,  1'b1, 1'b1, 32'hFFFF_FFFF, 5'd2},
      // get far past the count
      '{1'b0, 5'd0,  ACT_GET,      32'h0000_0000, 4'd15, 1'b1, 1'b0, 32'h0,         5'd2},
      // erase from the middle, head and tail
      '{1'b0, 5'd0,  ACT_INSERT,   32'h1234_5678, 4'd15, 1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_INSERT,   32'hA5A5_A5A5, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_ERASE,    32'hFFFF_FFFF, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_GET,      32'h0000_0000, 4'd1,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_CONTAINS, 32'hFFFF_FFFF, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_ERASE,    32'h0000_0000, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_ERASE,    32'hA5A5_A5A5, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      // capacity at the count, then zero with one value still held
      '{1'b1, 5'd1,  ACT_INSERT,   32'h0000_0000, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_INSERT,   32'h0000_0077, 4'd0,  1'b1, 1'b0, 32'h0,         5'd1},
      '{1'b1, 5'd0,  ACT_INSERT,   32'h0000_0000, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_INSERT,   32'h0000_0088, 4'd0,  1'b1, 1'b0, 32'h0,         5'd1},
      '{1'b0, 5'd0,  ACT_GET,      32'h0000_0000, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_CONTAINS, 32'h1234_5678, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_ERASE,    32'h1234_5678, 4'd0,  1'b1, 1'b1, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_INSERT,   32'h0000_0001, 4'd0,  1'b1, 1'b0, 32'h0,         5'd0},
      // capacity above the depth saturates
      '{1'b1, 5'd31, ACT_INSERT,   32'h0000_0000, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_INSERT,   32'h5A5A_5A5A, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_INSERT,   32'h0000_0000, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b0, 5'd0,  ACT_GET,      32'h0000_0000, 4'd1,  1'b0, 1'b0, 32'h0,         5'd0},
      '{1'b1, 5'd16, ACT_INSERT,   32'h0000_0000, 4'd0,  1'b0, 1'b0, 32'h0,         5'd0}
   };

   // capacity used by each random phase, extremes included
   logic [CAP_W-1:0] phase_caps [PHASE_COUNT] = '{5'd16, 5'd3, 5'd31, 5'd1,
                                                  5'd8, 5'd0, 5'd16, 5'd5};

   bounded_value_set_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value[31:0], index[35:32], zero pad
      .req_tuser  (req_tuser),   // action[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // item[31:0], count[36:32], zero pad
      .rsp_tuser  (rsp_tuser),   // ok[0]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // set model: applies one action to the bench copy and returns the response
   function automatic set_rsp_type apply_action(logic [ACTION_W-1:0] act,
                                                logic [REQ_VALUE_W-1:0] val,
                                                logic [INDEX_W-1:0] idx);
      set_rsp_type r;
      int unsigned limit;
      int unsigned pos;
      bit          found;
      r      = '0;
      limit  = (set_capacity > SET_DEPTH) ? SET_DEPTH : set_capacity;
      pos    = set_count;
      found  = 1'b0;
      // key compare against every held entry, first match wins
      for (int i = 0; i < set_count; i++) begin
         if (!found && set_vals[i] == val) begin
            pos   = i;
            found = 1'b1;
         end
      end
      case (act)
         ACT_INSERT: begin
            if (!found && set_count < limit) begin
               set_vals[set_count] = val;
               set_count++;
               r.ok = 1'b1;
               inserts_taken++;
            end
         end
         ACT_ERASE: begin
            // close the gap so insertion order survives
            if (found) begin
               for (int j = pos; j + 1 < set_count; j++) begin
                  set_vals[j] = set_vals[j + 1];
               end
               set_count--;
               r.ok = 1'b1;
            end
         end
         ACT_CONTAINS: begin
            r.ok = found;
         end
         default: begin
            if (idx < set_count) begin
               r.item = set_vals[idx];
               r.ok   = 1'b1;
               gets_hit++;
            end
         end
      endcase
      r.count = set_count[COUNT_W-1:0];
      return r;
   endfunction

   // one line per mismatch, and a running count
   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // called at a falling edge, returns at a falling edge after the transaction
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [REQ_VALUE_W-1:0] val,
                               input logic [INDEX_W-1:0] idx,
                               input bit use_typed,
                               input set_rsp_type typed_rsp);
      set_rsp_type modeled;
      // random sender gaps before this transaction
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, idx, val};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      // the model always runs so its state tracks the dut
      modeled = apply_action(act, val, idx);
      rsp_due.push_back(use_typed ? typed_rsp : modeled);
      req_total++;
      @(negedge clock);
   endtask

   // hold off the request side until every owed response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
   endtask

   // capacity writes only with nothing in flight
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      set_capacity = cap;
      cap_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response side backpressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // response checker: each accepted response against the oldest prediction
   always @(posedge clock) begin
      set_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            report_mismatch("response transaction with nothing outstanding");
         end else begin
            want = rsp_due.pop_front();
            if (rsp_tuser[0] !== want.ok)
               report_mismatch($sformatf("ok got %b want %b", rsp_tuser[0], want.ok));
            if (rsp_tdata[31:0] !== want.item)
               report_mismatch($sformatf("item got %h want %h",
                                         rsp_tdata[31:0], want.item));
            if (rsp_tdata[36:32] !== want.count)
               report_mismatch($sformatf("count got %0d want %0d",
                                         rsp_tdata[36:32], want.count));
         end
      end
   end

   // stimulus
   initial begin
      logic [REQ_VALUE_W-1:0] pool [POOL_SIZE];
      logic [ACTION_W-1:0]    act;
      logic [REQ_VALUE_W-1:0] val;
      logic [INDEX_W-1:0]     idx;
      set_rsp_type            typed_rsp;
      int unsigned            pick;

      foreach (set_vals[i]) set_vals[i] = '0;

      // synchronous reset held from the start, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no idling on either side
      send_idle_pct = 0;
      stall_pct     = 0;
      foreach (dir_rows[r]) begin
         if (dir_rows[r].is_cfg) begin
            write_capacity(dir_rows[r].cap);
         end else begin
            typed_rsp = '{dir_rows[r].ok, dir_rows[r].item, dir_rows[r].count};
            send_request(dir_rows[r].act, dir_rows[r].val, dir_rows[r].idx,
                         dir_rows[r].typed, typed_rsp);
         end
      end

      // value pool keeps hits and duplicates frequent; extremes always in it
      pool[0] = 32'h0000_0000;
      pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_capacity(phase_caps[p]);
         // rotate through none, sender idle, receiver stall, both
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mid-phase pause until the pipe is empty
            if (n == PHASE_ITEMS / 2) drain_responses();
            pick = $urandom_range(99);
            if (pick < 40)      act = ACT_INSERT;
            else if (pick < 65) act = ACT_ERASE;
            else if (pick < 80) act = ACT_CONTAINS;
            else                act = ACT_GET;
            val = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)]
                                            : $urandom;
            // gets mostly inside the held range, some anywhere
            if ($urandom_range(99) < 30 || set_count == 0)
               idx = INDEX_W'($urandom_range(SET_DEPTH - 1));
            else
               idx = INDEX_W'($urandom_range(set_count - 1));
            send_request(act, val, idx, 1'b0, '0);
         end
      end

      // let everything drain, then idle quietly to catch stray responses
      drain_responses();
      repeat (10) @(negedge clock);

      $display("run covered %0d requests under %0d capacity writes",
               req_total, cap_writes);
      $display("inserts taken %0d, gets that hit %0d", inserts_taken, gets_hit);
      if (error_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #5ms;
      $display("ERROR: run did not complete in time");
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/bvs_pkg.sv
src/bvs_cell.sv
src/bounded_value_set_top.sv
tb/tb_top.sv
